FILE: design/cdrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdrq_pkg;

  // width of the reported queue count, wraps modulo 64
  localparam int COUNT_BITS = 6;

  typedef enum logic {
    OP_ADD,
    OP_DISPATCH
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_TAIL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic scanning;
    logic empty;
    logic full;
  } back_stat_t;

endpackage

`default_nettype wire

FILE: design/cdrq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cdrq_req_if #(
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SECTOR_BITS-1:0] sector;
  logic                   is_write;
  logic [TAG_BITS-1:0]    tag;

  modport source (output valid, kind, sector, is_write, tag, input ready);
  modport sink   (input valid, kind, sector, is_write, tag, output ready);
endinterface

`default_nettype wire

FILE: design/cdrq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cdrq_rsp_if #(
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
);
  logic                             valid;
  logic                             ready;
  logic                             dispatched;
  logic [SECTOR_BITS-1:0]           out_sector;
  logic                             out_is_write;
  logic [TAG_BITS-1:0]              out_tag;
  logic                             rejected;
  logic [cdrq_pkg::COUNT_BITS-1:0]  queue_count;

  modport source (output valid, dispatched, out_sector, out_is_write, out_tag, rejected,
                  queue_count, input ready);
  modport sink   (input valid, dispatched, out_sector, out_is_write, out_tag, rejected,
                  queue_count, output ready);
endinterface

`default_nettype wire

FILE: design/clook_disk_request_queue.sv
// channel  dir  handshake          payload
// in_req   in   valid/ready        kind, sector, is_write, tag
// out_rsp  out  valid/ready        dispatched, out_sector, out_is_write, out_tag,
//                                  rejected, queue_count
//
// a request waits in the two-slot command queue until the back end takes it; a
// dispatch reads the head entry, an add to a queue neither full nor empty ripples
// through the queued entries over the single ram read port, and an add to a full or
// empty queue or a dispatch from an empty one goes straight to the result.
// rst_n is synchronous: queue empty, head all ones, no result pending.
// out_rsp low stalls only the back end; in_req stays open until the command queue fills.
`timescale 1ns / 1ps
`default_nettype none

module clook_disk_request_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cdrq_req_if.sink   in_req,
  cdrq_rsp_if.source out_rsp
);

  logic                   cmd_valid;
  cdrq_pkg::op_t          cmd_op;
  logic [SECTOR_BITS-1:0] cmd_sector;
  logic                   cmd_is_write;
  logic [TAG_BITS-1:0]    cmd_tag;
  logic                   cmd_pop;
  cdrq_pkg::back_stat_t   stat;

  cdrq_front #(
    .SECTOR_BITS(SECTOR_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cmd_valid   (cmd_valid),
    .cmd_op      (cmd_op),
    .cmd_sector  (cmd_sector),
    .cmd_is_write(cmd_is_write),
    .cmd_tag     (cmd_tag),
    .cmd_pop     (cmd_pop)
  );

  cdrq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SECTOR_BITS(SECTOR_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_op      (cmd_op),
    .cmd_sector  (cmd_sector),
    .cmd_is_write(cmd_is_write),
    .cmd_tag     (cmd_tag),
    .cmd_pop     (cmd_pop),
    .out_rsp     (out_rsp),
    .stat        (stat)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> stat.empty)
    else $error("queue not empty after reset");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("queue both full and empty");

  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scanning |-> !stat.empty && !stat.full)
    else $error("insert scan on an empty or full queue");

  a_disp_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.dispatched |-> !out_rsp.rejected)
    else $error("dispatch result flagged as rejected");
`endif

endmodule

`default_nettype wire

FILE: design/cdrq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cdrq_ram #(
  parameter int WIDTH  = 57,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/cdrq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cdrq_front #(
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  cdrq_req_if.sink                    in_req,
  output logic                        cmd_valid,
  output cdrq_pkg::op_t               cmd_op,
  output logic [SECTOR_BITS-1:0]      cmd_sector,
  output logic                        cmd_is_write,
  output logic [TAG_BITS-1:0]         cmd_tag,
  input  wire logic                   cmd_pop
);

  // two-slot command queue towards the back end
  localparam int SLOTS = 2;

  cdrq_pkg::op_t          op_r     [SLOTS];
  logic [SECTOR_BITS-1:0] sector_r [SLOTS];
  logic                   wr_r     [SLOTS];
  logic [TAG_BITS-1:0]    tag_r    [SLOTS];
  logic                   wptr_r, wptr_nxt;
  logic                   rptr_r, rptr_nxt;
  logic [1:0]             fill_r, fill_nxt;
  logic                   push;
  logic                   pop;
  cdrq_pkg::op_t          op_in;

  assign in_req.ready = (fill_r != 2'(SLOTS));
  assign push         = in_req.valid && in_req.ready;
  assign pop          = cmd_pop && cmd_valid;
  assign op_in        = in_req.kind ? cdrq_pkg::OP_DISPATCH : cdrq_pkg::OP_ADD;

  assign cmd_valid    = (fill_r != 2'd0);
  assign cmd_op       = op_r[rptr_r];
  assign cmd_sector   = sector_r[rptr_r];
  assign cmd_is_write = wr_r[rptr_r];
  assign cmd_tag      = tag_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    fill_nxt = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_r[wptr_r]     <= op_in;
      sector_r[wptr_r] <= in_req.sector;
      wr_r[wptr_r]     <= in_req.is_write;
      tag_r[wptr_r]    <= in_req.tag;
    end
  end

endmodule

`default_nettype wire

FILE: design/cdrq_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cdrq_back #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cmd_valid,
  input  wire cdrq_pkg::op_t          cmd_op,
  input  wire logic [SECTOR_BITS-1:0] cmd_sector,
  input  wire logic                   cmd_is_write,
  input  wire logic [TAG_BITS-1:0]    cmd_tag,
  output logic                        cmd_pop,
  cdrq_rsp_if.source                  out_rsp,
  output cdrq_pkg::back_stat_t        stat
);

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = SECTOR_BITS + 1 + TAG_BITS;

  cdrq_pkg::state_t       state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       base_r, base_nxt;
  logic [SECTOR_BITS-1:0] head_r, head_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   found_r, found_nxt;
  logic                   s_gt_h_r, s_gt_h_nxt;
  logic [SECTOR_BITS-1:0] sec_r, sec_nxt;
  logic [ENTRY_W-1:0]     carry_r, carry_nxt;

  logic                   res_disp_r, res_disp_nxt;
  logic [SECTOR_BITS-1:0] res_sector_r, res_sector_nxt;
  logic                   res_wr_r, res_wr_nxt;
  logic [TAG_BITS-1:0]    res_tag_r, res_tag_nxt;
  logic                   res_rej_r, res_rej_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_disp_r, out_disp_nxt;
  logic [SECTOR_BITS-1:0] out_sector_r, out_sector_nxt;
  logic                   out_wr_r, out_wr_nxt;
  logic [TAG_BITS-1:0]    out_tag_r, out_tag_nxt;
  logic                   out_rej_r, out_rej_nxt;
  logic [cdrq_pkg::COUNT_BITS-1:0] out_cnt_r, out_cnt_nxt;

  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [ENTRY_W-1:0]     wdata;
  logic [IDX_W-1:0]       raddr;
  logic [ENTRY_W-1:0]     rdata;

  logic                   empty;
  logic                   full;
  logic                   last;
  logic                   out_free;
  logic [SECTOR_BITS-1:0] c_sector;
  logic                   hit;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
                                            input logic [IDX_W-1:0] i);
    logic [IDX_W:0] sum;
    sum = {1'b0, b} + {1'b0, i};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  cdrq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign last     = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign out_free = !out_valid_r || out_rsp.ready;
  assign c_sector = rdata[ENTRY_W-1 -: SECTOR_BITS];

  // c-look placement: above the head goes before the wrap, otherwise after it
  assign hit = found_r ||
               (s_gt_h_r ? ((c_sector < head_r) || (sec_r < c_sector))
                         : ((c_sector < head_r) && (sec_r < c_sector)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdrq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_op == cdrq_pkg::OP_DISPATCH) begin
            state_nxt = empty ? cdrq_pkg::ST_RESP : cdrq_pkg::ST_POP;
          end else begin
            state_nxt = (full || empty) ? cdrq_pkg::ST_RESP : cdrq_pkg::ST_SCAN;
          end
        end
      end
      cdrq_pkg::ST_POP:  state_nxt = cdrq_pkg::ST_RESP;
      cdrq_pkg::ST_SCAN: state_nxt = last ? cdrq_pkg::ST_TAIL : cdrq_pkg::ST_SCAN;
      cdrq_pkg::ST_TAIL: state_nxt = cdrq_pkg::ST_RESP;
      cdrq_pkg::ST_RESP: state_nxt = out_free ? cdrq_pkg::ST_IDLE : cdrq_pkg::ST_RESP;
      default:           state_nxt = cdrq_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop        = 1'b0;
    count_nxt      = count_r;
    base_nxt       = base_r;
    head_nxt       = head_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    s_gt_h_nxt     = s_gt_h_r;
    sec_nxt        = sec_r;
    carry_nxt      = carry_r;
    res_disp_nxt   = res_disp_r;
    res_sector_nxt = res_sector_r;
    res_wr_nxt     = res_wr_r;
    res_tag_nxt    = res_tag_r;
    res_rej_nxt    = res_rej_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_disp_nxt   = out_disp_r;
    out_sector_nxt = out_sector_r;
    out_wr_nxt     = out_wr_r;
    out_tag_nxt    = out_tag_r;
    out_rej_nxt    = out_rej_r;
    out_cnt_nxt    = out_cnt_r;
    we             = 1'b0;
    waddr          = base_r;
    wdata          = carry_r;
    raddr          = phys(base_r, '0);

    unique case (state_r)
      cdrq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          sec_nxt        = cmd_sector;
          s_gt_h_nxt     = (cmd_sector > head_r);
          found_nxt      = 1'b0;
          idx_nxt        = '0;
          carry_nxt      = {cmd_sector, cmd_is_write, cmd_tag};
          res_disp_nxt   = 1'b0;
          res_sector_nxt = '0;
          res_wr_nxt     = 1'b0;
          res_tag_nxt    = '0;
          res_rej_nxt    = 1'b0;
          if (cmd_op == cdrq_pkg::OP_ADD) begin
            if (full) begin
              res_rej_nxt = 1'b1;
            end else if (empty) begin
              we        = 1'b1;
              waddr     = base_r;
              wdata     = {cmd_sector, cmd_is_write, cmd_tag};
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
      end
      cdrq_pkg::ST_POP: begin
        res_disp_nxt   = 1'b1;
        res_sector_nxt = c_sector;
        res_wr_nxt     = rdata[TAG_BITS];
        res_tag_nxt    = rdata[TAG_BITS-1:0];
        head_nxt       = c_sector;
        base_nxt       = phys(base_r, IDX_W'(1));
        count_nxt      = count_r - CNT_W'(1);
      end
      cdrq_pkg::ST_SCAN: begin
        // ripple insert: write the held entry, pick up the one displaced
        if (hit) begin
          we        = 1'b1;
          waddr     = phys(base_r, idx_r);
          wdata     = carry_r;
          carry_nxt = rdata;
          found_nxt = 1'b1;
        end
        raddr   = phys(base_r, idx_r + IDX_W'(1));
        idx_nxt = idx_r + IDX_W'(1);
      end
      cdrq_pkg::ST_TAIL: begin
        we        = 1'b1;
        waddr     = phys(base_r, count_r[IDX_W-1:0]);
        wdata     = carry_r;
        count_nxt = count_r + CNT_W'(1);
      end
      cdrq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_disp_nxt   = res_disp_r;
          out_sector_nxt = res_sector_r;
          out_wr_nxt     = res_wr_r;
          out_tag_nxt    = res_tag_r;
          out_rej_nxt    = res_rej_r;
          out_cnt_nxt    = cdrq_pkg::COUNT_BITS'(count_r);
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdrq_pkg::ST_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      head_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    s_gt_h_r     <= s_gt_h_nxt;
    sec_r        <= sec_nxt;
    carry_r      <= carry_nxt;
    res_disp_r   <= res_disp_nxt;
    res_sector_r <= res_sector_nxt;
    res_wr_r     <= res_wr_nxt;
    res_tag_r    <= res_tag_nxt;
    res_rej_r    <= res_rej_nxt;
    out_disp_r   <= out_disp_nxt;
    out_sector_r <= out_sector_nxt;
    out_wr_r     <= out_wr_nxt;
    out_tag_r    <= out_tag_nxt;
    out_rej_r    <= out_rej_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.dispatched   = out_disp_r;
  assign out_rsp.out_sector   = out_sector_r;
  assign out_rsp.out_is_write = out_wr_r;
  assign out_rsp.out_tag      = out_tag_r;
  assign out_rsp.rejected     = out_rej_r;
  assign out_rsp.queue_count  = out_cnt_r;

  assign stat.scanning = (state_r == cdrq_pkg::ST_SCAN);
  assign stat.empty    = empty;
  assign stat.full     = full;

endmodule

`default_nettype wire

FILE: sim/clook_disk_request_queue_test.sv
`timescale 1ns / 1ps

module clook_disk_request_queue_test;

  localparam int QUEUE_DEPTH = 32;
  localparam int SECTOR_BITS = 48;
  localparam int TAG_BITS    = 8;
  localparam int RANDOM_REQUESTS = 1200;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int MAX_PRINTED = 40;

  // sector distributions for generated adds
  localparam int SECT_WIDE  = 0;
  localparam int SECT_LOW   = 1;
  localparam int SECT_HIGH  = 2;
  localparam int SECT_MIXED = 3;

  localparam logic [SECTOR_BITS-1:0] SECTOR_MAX = '1;

  typedef struct {
    cdrq_pkg::op_t          kind;
    logic [SECTOR_BITS-1:0] sector;
    logic                   is_write;
    logic [TAG_BITS-1:0]    tag;
  } disk_req_t;

  typedef struct {
    logic                   dispatched;
    logic [SECTOR_BITS-1:0] sector;
    logic                   is_write;
    logic [TAG_BITS-1:0]    tag;
    logic                   rejected;
    logic [cdrq_pkg::COUNT_BITS-1:0] count;
  } disk_rsp_t;

  typedef struct {
    logic [SECTOR_BITS-1:0] sector;
    logic                   is_write;
    logic [TAG_BITS-1:0]    tag;
  } sched_slot_t;

  logic clk = 1'b0;
  logic rst_n;

  cdrq_req_if #(.SECTOR_BITS(SECTOR_BITS), .TAG_BITS(TAG_BITS)) req_bus ();
  cdrq_rsp_if #(.SECTOR_BITS(SECTOR_BITS), .TAG_BITS(TAG_BITS)) rsp_bus ();

  clook_disk_request_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SECTOR_BITS(SECTOR_BITS),
    .TAG_BITS(TAG_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(req_bus),
    .out_rsp(rsp_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scheduler image kept by the testbench
  sched_slot_t            sched_slots [QUEUE_DEPTH];
  int                     sched_count = 0;
  logic [SECTOR_BITS-1:0] sched_head = SECTOR_MAX;

  disk_req_t request_backlog [$];
  disk_rsp_t expected_rsps [$];
  int        backlog_depth_est = 0;
  int        err_count = 0;
  int        accepted_reqs = 0;
  bit        req_taken = 1'b0;

  function automatic disk_rsp_t serve_request(disk_req_t r);
    disk_rsp_t   rsp;
    sched_slot_t front;
    logic [SECTOR_BITS-1:0] c;
    int pos;
    int i;
    rsp = '{default: '0};
    if (r.kind == cdrq_pkg::OP_ADD) begin
      if (sched_count >= QUEUE_DEPTH) begin
        rsp.rejected = 1'b1;
      end else begin
        // walk from the back so the lowest matching slot wins
        pos = sched_count;
        for (i = sched_count - 1; i >= 0; i--) begin
          c = sched_slots[i].sector;
          if (r.sector > sched_head) begin
            if (c < sched_head || r.sector < c) pos = i;
          end else begin
            if (c < sched_head && r.sector < c) pos = i;
          end
        end
        for (i = sched_count; i > pos; i--) sched_slots[i] = sched_slots[i-1];
        sched_slots[pos] = '{sector: r.sector, is_write: r.is_write, tag: r.tag};
        sched_count++;
      end
    end else if (sched_count > 0) begin
      front = sched_slots[0];
      for (i = 1; i < sched_count; i++) sched_slots[i-1] = sched_slots[i];
      sched_count--;
      sched_head = front.sector;
      rsp.dispatched = 1'b1;
      rsp.sector = front.sector;
      rsp.is_write = front.is_write;
      rsp.tag = front.tag;
    end
    rsp.count = sched_count[cdrq_pkg::COUNT_BITS-1:0];
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
  endtask

  task automatic queue_request(cdrq_pkg::op_t k, logic [SECTOR_BITS-1:0] s, logic w,
                               logic [TAG_BITS-1:0] t);
    request_backlog.push_back('{kind: k, sector: s, is_write: w, tag: t});
    if (k == cdrq_pkg::OP_ADD) begin
      if (backlog_depth_est < QUEUE_DEPTH) backlog_depth_est++;
    end else if (backlog_depth_est > 0) begin
      backlog_depth_est--;
    end
  endtask

  function automatic logic [SECTOR_BITS-1:0] pick_sector(int mode);
    logic [SECTOR_BITS-1:0] s;
    int m;
    m = (mode == SECT_MIXED) ? $urandom_range(SECT_WIDE, SECT_HIGH) : mode;
    if (m == SECT_LOW) begin
      s = SECTOR_BITS'($urandom_range(0, 12));
    end else if (m == SECT_HIGH) begin
      s = SECTOR_MAX - SECTOR_BITS'($urandom_range(0, 12));
    end else begin
      s[SECTOR_BITS-1:32] = (SECTOR_BITS-32)'($urandom_range(0, 65535));
      s[31:0] = $urandom();
    end
    return s;
  endfunction

  task automatic add_random(int mode);
    queue_request(cdrq_pkg::OP_ADD, pick_sector(mode), 1'($urandom_range(0, 1)),
                  TAG_BITS'($urandom_range(0, 255)));
  endtask

  task automatic dispatch_random();
    queue_request(cdrq_pkg::OP_DISPATCH, pick_sector(SECT_WIDE), 1'($urandom_range(0, 1)),
                  TAG_BITS'($urandom_range(0, 255)));
  endtask

  // stimulus and end of run
  initial begin
    int smode;
    int len;
    int i;
    rst_n = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.kind = cdrq_pkg::OP_ADD;
    req_bus.sector = '0;
    req_bus.is_write = 1'b0;
    req_bus.tag = '0;
    rsp_bus.ready = 1'b0;

    // directed: empty dispatch, field extremes, requests above, at and below the head
    queue_request(cdrq_pkg::OP_DISPATCH, '0, 1'b0, '0);
    queue_request(cdrq_pkg::OP_ADD, '0, 1'b0, '0);
    queue_request(cdrq_pkg::OP_ADD, SECTOR_MAX, 1'b1, '1);
    queue_request(cdrq_pkg::OP_ADD, 48'h8000_0000_0000, 1'b0, 8'h55);
    queue_request(cdrq_pkg::OP_ADD, 48'h7FFF_FFFF_FFFF, 1'b1, 8'hAA);
    queue_request(cdrq_pkg::OP_ADD, 48'h1, 1'b0, 8'h01);
    queue_request(cdrq_pkg::OP_DISPATCH, SECTOR_MAX, 1'b1, '1);
    queue_request(cdrq_pkg::OP_DISPATCH, '0, 1'b0, '0);
    queue_request(cdrq_pkg::OP_ADD, 48'h0, 1'b1, 8'h10);
    queue_request(cdrq_pkg::OP_ADD, 48'h1, 1'b0, 8'h11);
    queue_request(cdrq_pkg::OP_ADD, 48'h5, 1'b1, 8'h12);
    queue_request(cdrq_pkg::OP_ADD, 48'h1, 1'b1, 8'h13);
    for (i = 0; i < 8; i++) queue_request(cdrq_pkg::OP_DISPATCH, '0, 1'b0, '0);
    // head now at sector 48'h8000_0000_0000: one lower and two higher requests
    queue_request(cdrq_pkg::OP_ADD, 48'h3, 1'b0, 8'h20);
    queue_request(cdrq_pkg::OP_ADD, SECTOR_MAX, 1'b1, 8'h21);
    queue_request(cdrq_pkg::OP_ADD, SECTOR_MAX - 1, 1'b0, 8'h22);
    for (i = 0; i < 4; i++) queue_request(cdrq_pkg::OP_DISPATCH, '0, 1'b0, '0);

    len = request_backlog.size() + RANDOM_REQUESTS;
    while (request_backlog.size() < len) begin
      smode = $urandom_range(SECT_WIDE, SECT_MIXED);
      if ($urandom_range(0, 3) == 0) begin
        // fill to full and sometimes past it, then drain, sometimes past empty
        while (backlog_depth_est < QUEUE_DEPTH) add_random(smode);
        repeat ($urandom_range(0, 3)) add_random(smode);
        repeat ($urandom_range(1, QUEUE_DEPTH + 2)) dispatch_random();
      end else begin
        repeat ($urandom_range(20, 60)) begin
          if ($urandom_range(0, 99) < 45) dispatch_random();
          else add_random(smode);
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_backlog.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[clook_disk_request_queue] OK");
    end else begin
      $display("[clook_disk_request_queue] ERROR");
    end
    $finish;
  end

  // driver: bursts of requests with random gaps
  int burst_left = 1;
  int gap_left = 0;
  bit offering = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (req_taken) begin
        void'(request_backlog.pop_front());
        req_taken = 1'b0;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_backlog.size() != 0) begin
          offering = 1'b1;
          req_bus.kind <= request_backlog[0].kind;
          req_bus.sector <= request_backlog[0].sector;
          req_bus.is_write <= request_backlog[0].is_write;
          req_bus.tag <= request_backlog[0].tag;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      req_bus.valid <= offering;
    end
  end

  // receiver: changing stall pattern plus two long hold-offs
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;
  int holdoff_left = 0;
  int holdoffs_done = 0;

  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (rst_n) begin
      if (holdoff_left > 0) begin
        holdoff_left--;
        rdy = 1'b0;
      end else if (holdoffs_done < 2 && accepted_reqs >= 300 + 600 * holdoffs_done) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoffs_done++;
        rdy = 1'b0;
      end else begin
        if (mode_left <= 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (stall_phase % 5) != 4;
          default: rdy = $urandom_range(0, 7) == 0;
        endcase
      end
    end else begin
      rdy = 1'b0;
    end
    rsp_bus.ready <= rdy;
  end

  // monitor: predict on accepted requests, check each response against the oldest
  always @(posedge clk) begin
    disk_req_t r;
    disk_rsp_t got;
    disk_rsp_t want;
    if (rst_n) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.dispatched = rsp_bus.dispatched;
        got.sector = rsp_bus.out_sector;
        got.is_write = rsp_bus.out_is_write;
        got.tag = rsp_bus.out_tag;
        got.rejected = rsp_bus.rejected;
        got.count = rsp_bus.queue_count;
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with no request outstanding", 64'(got.sector), 64'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (got.dispatched !== want.dispatched)
            report_mismatch("dispatched", 64'(got.dispatched), 64'(want.dispatched));
          if (got.sector !== want.sector)
            report_mismatch("out_sector", 64'(got.sector), 64'(want.sector));
          if (got.is_write !== want.is_write)
            report_mismatch("out_is_write", 64'(got.is_write), 64'(want.is_write));
          if (got.tag !== want.tag)
            report_mismatch("out_tag", 64'(got.tag), 64'(want.tag));
          if (got.rejected !== want.rejected)
            report_mismatch("rejected", 64'(got.rejected), 64'(want.rejected));
          if (got.count !== want.count)
            report_mismatch("queue_count", 64'(got.count), 64'(want.count));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        r.kind = cdrq_pkg::op_t'(req_bus.kind);
        r.sector = req_bus.sector;
        r.is_write = req_bus.is_write;
        r.tag = req_bus.tag;
        expected_rsps.push_back(serve_request(r));
        accepted_reqs++;
        req_taken = 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[clook_disk_request_queue] ERROR");
        $finish;
      end
    end
  end

endmodule
